>>> hdl/keyed_record_table_unit_assert.svh
// ----------------------------------------------------------------------------
// keyed_record_table_unit assertion macros
// shared assertion forms for the keyed record table checker
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_TABLE_UNIT_ASSERT_SVH
`define KEYED_RECORD_TABLE_UNIT_ASSERT_SVH

// property checked outside reset
`define KRT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define KRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// types and codes shared by the keyed record table modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package krt_pkg;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_SEARCH = 2'd1,
        FN_UPDATE = 2'd2,
        FN_DUMP   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_DUP   = 3'd2,
        ST_MISS  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    // where the result fields come from
    typedef enum logic [1:0] {
        RK_REC = 2'd0,
        RK_UPD = 2'd1,
        RK_INS = 2'd2,
        RK_ERR = 2'd3
    } resp_kind_t;

    typedef struct packed {
        logic [31:0] key;
        logic [63:0] name;
        logic [31:0] qty;
    } rec_t;

    typedef struct packed {
        logic       accept;
        logic       rd_en;
        logic       load;
        resp_kind_t kind;
        status_t    status;
        logic       last;
    } krt_cmd_t;

    typedef struct packed {
        logic hit;
        logic rd_vld;
        logic out_free;
    } krt_stat_t;

    localparam logic [31:0] QTY_MAX = 32'h7fff_ffff;
    localparam logic [31:0] QTY_MIN = 32'h8000_0000;

endpackage

>>> hdl/krt_ctrl.sv
// ----------------------------------------------------------------------------
// krt_ctrl
// command sequencer: key scan, response hand-off and record dump
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module krt_ctrl import krt_pkg::*; #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_valid,
    input  logic [1:0]                                      s_func,
    output logic                                            s_ready,
    input  krt_stat_t                                       stat,
    output krt_cmd_t                                        cmd,
    output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] rd_idx,
    output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] ins_idx
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESP,
        S_DRD,
        S_DLD
    } state_t;

    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    resp_kind_t         kind_reg, kind_next;
    status_t            status_reg, status_next;
    logic               dump_last;

    assign dump_last = (CNT_W'(idx_reg + 1'b1) == count_reg);
    assign s_ready   = (state_reg == S_IDLE);
    assign rd_idx    = idx_reg[IDX_W-1:0];
    assign ins_idx   = count_reg[IDX_W-1:0];

    always_comb begin
        cmd.accept = (state_reg == S_IDLE) && s_valid;
        cmd.rd_en  = ((state_reg == S_SCAN) && !stat.hit && (idx_reg < count_reg))
                     || (state_reg == S_DRD);
        cmd.load   = ((state_reg == S_RESP) || (state_reg == S_DLD)) && stat.out_free;
        cmd.kind   = (state_reg == S_DLD) ? RK_REC : kind_reg;
        cmd.status = (state_reg == S_DLD) ? ST_OK : status_reg;
        cmd.last   = (state_reg == S_DLD) ? dump_last : 1'b1;
    end

    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next = func_t'(s_func);
                    idx_next  = '0;
                    case (func_t'(s_func))
                        FN_DUMP: begin
                            if (count_reg == '0) begin
                                kind_next   = RK_ERR;
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end else begin
                                state_next = S_DRD;
                            end
                        end
                        FN_INSERT: begin
                            if (count_reg == CNT_W'(MAX_ENTRIES)) begin
                                kind_next   = RK_ERR;
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: state_next = S_SCAN;
                    endcase
                end
            end
            S_SCAN: begin
                if (stat.hit) begin
                    state_next = S_RESP;
                    case (func_reg)
                        FN_INSERT: begin
                            kind_next   = RK_ERR;
                            status_next = ST_DUP;
                        end
                        FN_UPDATE: begin
                            kind_next   = RK_UPD;
                            status_next = ST_OK;
                        end
                        default: begin
                            kind_next   = RK_REC;
                            status_next = ST_OK;
                        end
                    endcase
                end else if (idx_reg < count_reg) begin
                    idx_next = CNT_W'(idx_reg + 1'b1);
                end else if (!stat.rd_vld) begin
                    // every stored key compared, none matched
                    state_next = S_RESP;
                    if (func_reg == FN_INSERT) begin
                        kind_next   = RK_INS;
                        status_next = ST_OK;
                    end else begin
                        kind_next   = RK_ERR;
                        status_next = ST_MISS;
                    end
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    if (kind_reg == RK_INS) begin
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                    state_next = S_IDLE;
                end
            end
            S_DRD: begin
                state_next = S_DLD;
            end
            S_DLD: begin
                if (stat.out_free) begin
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = CNT_W'(idx_reg + 1'b1);
                        state_next = S_DRD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            func_reg   <= FN_INSERT;
            idx_reg    <= '0;
            count_reg  <= '0;
            kind_reg   <= RK_ERR;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            func_reg   <= func_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
        end
    end

endmodule

>>> hdl/krt_datapath.sv
// ----------------------------------------------------------------------------
// krt_datapath
// record memory, key compare, saturating update and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module krt_datapath import krt_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int NAME_CHARS  = 8
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic signed [31:0]                              s_key,
    input  logic [63:0]                                     s_rec_name,
    input  logic signed [31:0]                              s_quantity,
    input  logic signed [31:0]                              s_delta,
    input  krt_cmd_t                                        cmd,
    output krt_stat_t                                       stat,
    input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] rd_idx,
    input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] ins_idx,
    output logic                                            m_valid,
    input  logic                                            m_ready,
    output logic [2:0]                                      m_status,
    output logic signed [31:0]                              m_out_key,
    output logic [63:0]                                     m_out_name,
    output logic signed [31:0]                              m_out_quantity,
    output logic                                            m_last
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [63:0] NAME_MASK = {64{1'b1}} >> (64 - 8 * NAME_CHARS);

    rec_t               mem [MAX_ENTRIES];

    logic [31:0]        key_reg;
    logic [63:0]        name_reg;
    logic [31:0]        qty_reg;
    logic [31:0]        delta_reg;

    rec_t               rdata_reg;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_at_reg;

    logic               m_valid_reg, m_valid_next;
    rec_t               out_rec_reg;
    status_t            out_status_reg;
    logic               out_last_reg;

    logic signed [32:0] upd_sum;
    logic [31:0]        upd_qty;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    rec_t               wr_data;
    rec_t               out_rec;

    // one entry read per cycle, data valid the cycle after
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_idx];
            rd_at_reg <= rd_idx;
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            key_reg   <= s_key;
            name_reg  <= s_rec_name & NAME_MASK;
            qty_reg   <= s_quantity;
            delta_reg <= s_delta;
        end
    end

    assign stat.hit      = rd_vld_reg && (rdata_reg.key == key_reg);
    assign stat.rd_vld   = rd_vld_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign upd_sum = {rdata_reg.qty[31], rdata_reg.qty} + {delta_reg[31], delta_reg};

    always_comb begin
        // overflow when the two top bits of the 33-bit sum disagree
        if (upd_sum[32] != upd_sum[31]) begin
            upd_qty = upd_sum[32] ? QTY_MIN : QTY_MAX;
        end else begin
            upd_qty = upd_sum[31:0];
        end
    end

    assign wr_en   = cmd.load && ((cmd.kind == RK_UPD) || (cmd.kind == RK_INS));
    assign wr_addr = (cmd.kind == RK_INS) ? ins_idx : rd_at_reg;

    always_comb begin
        if (cmd.kind == RK_INS) begin
            wr_data = '{key: key_reg, name: name_reg, qty: qty_reg};
        end else begin
            wr_data = '{key: rdata_reg.key, name: rdata_reg.name, qty: upd_qty};
        end
    end

    always_comb begin
        case (cmd.kind)
            RK_REC:  out_rec = rdata_reg;
            RK_UPD:  out_rec = wr_data;
            RK_INS:  out_rec = wr_data;
            default: out_rec = '0;
        endcase
    end

    always_comb begin
        rd_vld_next  = cmd.rd_en;
        m_valid_next = m_valid_reg;
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_rec_reg    <= out_rec;
            out_status_reg <= cmd.status;
            out_last_reg   <= cmd.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_status_reg;
    assign m_out_key      = out_rec_reg.key;
    assign m_out_name     = out_rec_reg.name;
    assign m_out_quantity = out_rec_reg.qty;
    assign m_last         = out_last_reg;

endmodule

>>> hdl/keyed_record_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// keyed record table with insert, search, saturating update and dump
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one command item (s_func, s_key, s_rec_name,
//   s_quantity, s_delta). m_ channel returns result items with m_status
//   and m_last; insert, search and update return one item, dump returns
//   one item per stored record (or one empty-status item).
//   records sit in a single-port-read record memory; a key lookup reads
//   one entry per cycle and stops at the first matching key; dump takes
//   each record in two steps: one memory read, one output load.
//   only one command is in flight; s_ready is high while the block is
//   idle, and a result waiting in the output register does not hold off
//   the next command.
//   reset empties the table and drops any pending result; stored entries
//   are not cleared, only the entry count.
//   when m_ready is low the output register holds its item and the
//   sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyed_record_table_unit import krt_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int NAME_CHARS  = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic signed [31:0] s_key,
    input  logic [63:0]        s_rec_name,
    input  logic signed [31:0] s_quantity,
    input  logic signed [31:0] s_delta,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_out_key,
    output logic [63:0]        m_out_name,
    output logic signed [31:0] m_out_quantity,
    output logic               m_last
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    krt_cmd_t         cmd;
    krt_stat_t        stat;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] ins_idx;

    krt_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd),
        .rd_idx  (rd_idx),
        .ins_idx (ins_idx)
    );

    krt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NAME_CHARS  (NAME_CHARS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_key          (s_key),
        .s_rec_name     (s_rec_name),
        .s_quantity     (s_quantity),
        .s_delta        (s_delta),
        .cmd            (cmd),
        .stat           (stat),
        .rd_idx         (rd_idx),
        .ins_idx        (ins_idx),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_key      (m_out_key),
        .m_out_name     (m_out_name),
        .m_out_quantity (m_out_quantity),
        .m_last         (m_last)
    );

endmodule

>>> hdl/krt_checker.sv
// ----------------------------------------------------------------------------
// krt_checker
// port-level checks for the keyed record table, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyed_record_table_unit_assert.svh"

module krt_checker import krt_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_func,
    input logic signed [31:0] s_key,
    input logic [63:0]        s_rec_name,
    input logic signed [31:0] s_quantity,
    input logic signed [31:0] s_delta,
    input logic               m_valid,
    input logic               m_ready,
    input logic [2:0]         m_status,
    input logic signed [31:0] m_out_key,
    input logic [63:0]        m_out_name,
    input logic signed [31:0] m_out_quantity,
    input logic               m_last
);

    // stalled result item keeps its payload
    `KRT_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_key) && $stable(m_out_name) && $stable(m_out_quantity) && $stable(m_last), "result item changed while stalled")

    // error results are single items with zeroed record fields
    `KRT_ASSERT(a_err_zero, aclk, aresetn, m_valid && (m_status != ST_OK) |-> m_last && (m_out_key == 32'sd0) && (m_out_name == 64'd0) && (m_out_quantity == 32'sd0), "error result carries record data")

    // one command at a time: busy right after an accept
    `KRT_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "second item taken while a command is in flight")

    // reset drops any pending result
    `KRT_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (.*);

>>> tb/tb_keyed_record_table_unit.sv
// ----------------------------------------------------------------------------
// tb_keyed_record_table_unit
// drives insert, search, update and dump commands into the record table,
// keeps a shadow copy of the table to predict every result item and checks
// the result stream field by field under random sender gaps and receiver
// stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyed_record_table_unit;
    import krt_pkg::*;

    localparam int MAX_ENTRIES  = 64;
    localparam int NAME_CHARS   = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 150;
    localparam int ITEM_TARGET  = 210;
    localparam int PRINT_CAP    = 100;
    localparam logic [63:0] NAME_MASK = {64{1'b1}} >> (64 - 8 * NAME_CHARS);

    typedef struct {
        status_t     status;
        logic [31:0] key;
        logic [63:0] name;
        logic [31:0] qty;
        logic        last;
    } table_reply_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_func;
    logic signed [31:0] s_key;
    logic [63:0]        s_rec_name;
    logic signed [31:0] s_quantity;
    logic signed [31:0] s_delta;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_status;
    logic signed [31:0] m_out_key;
    logic [63:0]        m_out_name;
    logic signed [31:0] m_out_quantity;
    logic               m_last;

    // shadow of the record table
    logic [31:0]        tbl_key  [MAX_ENTRIES];
    logic [63:0]        tbl_name [MAX_ENTRIES];
    logic signed [31:0] tbl_qty  [MAX_ENTRIES];
    int                 tbl_count = 0;

    table_reply_t pending_replies[$];
    int err_count  = 0;
    int items_sent = 0;
    int burst_left = 0;
    int idle_count = 0;

    keyed_record_table_unit #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NAME_CHARS  (NAME_CHARS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_key          (s_key),
        .s_rec_name     (s_rec_name),
        .s_quantity     (s_quantity),
        .s_delta        (s_delta),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_key      (m_out_key),
        .m_out_name     (m_out_name),
        .m_out_quantity (m_out_quantity),
        .m_last         (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver: runs of always-ready, random ready and stall bursts
    initial begin : rx_pattern
        int mode;
        int mode_left;
        int stall_left;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
                0: begin
                    m_ready = 1'b1;
                end
                1: begin
                    m_ready = ($urandom_range(0, 2) != 0);
                end
                default: begin
                    if (stall_left > 0) begin
                        m_ready = 1'b0;
                        stall_left--;
                    end else begin
                        m_ready = 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            stall_left = $urandom_range(2, 10);
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        if (err_count < PRINT_CAP)
            $display("%0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(string fname, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", fname, got, want));
    endtask

    always @(posedge aclk) begin : reply_checker
        table_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("result item with no command pending");
            end else begin
                want = pending_replies.pop_front();
                check_field("status", 64'(m_status), 64'(want.status));
                // zero-extend both sides so signed ports compare bit for bit
                check_field("out_key", {32'd0, m_out_key}, {32'd0, want.key});
                check_field("out_name", m_out_name, want.name);
                check_field("out_quantity", {32'd0, m_out_quantity}, {32'd0, want.qty});
                check_field("last", 64'(m_last), 64'(want.last));
            end
        end
    end

    function automatic int find_key(logic [31:0] k);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    task automatic push_reply(status_t st, logic [31:0] k, logic [63:0] nm,
                              logic [31:0] q, logic lst);
        table_reply_t r;
        r.status = st;
        r.key    = k;
        r.name   = nm;
        r.qty    = q;
        r.last   = lst;
        pending_replies.push_back(r);
    endtask

    // updates the shadow table and queues the result items of one command
    task automatic apply_command(func_t fn, logic [31:0] k, logic [63:0] nm,
                                 logic [31:0] q, logic signed [31:0] d);
        int     idx;
        longint sum;
        case (fn)
            FN_INSERT: begin
                // full check wins over the duplicate check
                if (tbl_count >= MAX_ENTRIES) begin
                    push_reply(ST_FULL, '0, '0, '0, 1'b1);
                end else if (find_key(k) >= 0) begin
                    push_reply(ST_DUP, '0, '0, '0, 1'b1);
                end else begin
                    tbl_key[tbl_count]  = k;
                    tbl_name[tbl_count] = nm & NAME_MASK;
                    tbl_qty[tbl_count]  = q;
                    push_reply(ST_OK, k, nm & NAME_MASK, q, 1'b1);
                    tbl_count++;
                end
            end
            FN_SEARCH, FN_UPDATE: begin
                idx = find_key(k);
                if (idx < 0) begin
                    push_reply(ST_MISS, '0, '0, '0, 1'b1);
                end else begin
                    if (fn == FN_UPDATE) begin
                        sum = longint'(tbl_qty[idx]) + longint'(d);
                        if (sum > longint'(signed'(QTY_MAX)))
                            sum = longint'(signed'(QTY_MAX));
                        if (sum < longint'(signed'(QTY_MIN)))
                            sum = longint'(signed'(QTY_MIN));
                        tbl_qty[idx] = sum[31:0];
                    end
                    push_reply(ST_OK, tbl_key[idx], tbl_name[idx], tbl_qty[idx], 1'b1);
                end
            end
            default: begin
                if (tbl_count == 0) begin
                    push_reply(ST_EMPTY, '0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < tbl_count; i++)
                        push_reply(ST_OK, tbl_key[i], tbl_name[i], tbl_qty[i],
                                   i == tbl_count - 1);
                end
            end
        endcase
    endtask

    // valid drops for a random gap at the end of each burst
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(1, 6);
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_command(func_t fn, logic [31:0] k, logic [63:0] nm,
                                logic [31:0] q, logic [31:0] d);
        @(negedge aclk);
        s_valid    = 1'b1;
        s_func     = fn;
        s_key      = k;
        s_rec_name = nm;
        s_quantity = q;
        s_delta    = d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_command(fn, k, nm, q, d);
        items_sent++;
        pace_sender();
    endtask

    task automatic hold_sender_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_key(int hit_pct);
        if (tbl_count > 0 && $urandom_range(0, 99) < hit_pct)
            return tbl_key[$urandom_range(0, tbl_count - 1)];
        return $urandom;
    endfunction

    // quantities near the bounds so that updates saturate often
    function automatic logic [31:0] random_qty();
        case ($urandom_range(0, 3))
            0: return QTY_MAX - $urandom_range(0, 1000);
            1: return QTY_MIN + $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_delta();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 4000) - 2000;
            7: return QTY_MAX;
            8: return QTY_MIN;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int ins_pct, int dump_pct);
        int          r;
        func_t       fn;
        logic [31:0] k;
        r = $urandom_range(0, 99);
        if (r < dump_pct)
            fn = FN_DUMP;
        else if (r < dump_pct + ins_pct)
            fn = FN_INSERT;
        else if ($urandom_range(0, 1) == 0)
            fn = FN_SEARCH;
        else
            fn = FN_UPDATE;
        k = (fn == FN_INSERT) ? pick_key(12) : pick_key(80);
        send_command(fn, k, {$urandom, $urandom}, random_qty(), random_delta());
    endtask

    task automatic test_empty_table();
        send_command(FN_DUMP, '0, '0, '0, '0);
        send_command(FN_SEARCH, '0, '0, '0, '0);
        send_command(FN_UPDATE, QTY_MAX, '1, '1, QTY_MAX);
    endtask

    task automatic test_insert_extremes();
        send_command(FN_INSERT, QTY_MIN, '1, QTY_MAX, '1);
        send_command(FN_INSERT, QTY_MAX, '0, QTY_MIN, '0);
        send_command(FN_INSERT, '0, 64'h4847_4645_4443_4241, '0, '0);
        send_command(FN_INSERT, '1, {$urandom, $urandom}, '1, '0);
        send_command(FN_INSERT, 32'h5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555,
                     32'haaaa_aaaa);
    endtask

    task automatic test_duplicate_and_miss();
        send_command(FN_INSERT, '0, '1, 32'd77, '0);
        send_command(FN_SEARCH, QTY_MIN, '0, '0, '0);
        send_command(FN_SEARCH, 32'd5, '0, '0, '0);
        send_command(FN_UPDATE, 32'haaaa_aaaa, '0, '0, 32'd1);
    endtask

    task automatic test_update_saturation();
        // low clamp, high clamp, then sums that stay in range
        send_command(FN_UPDATE, QTY_MAX, '0, '0, QTY_MIN);
        send_command(FN_UPDATE, QTY_MIN, '0, '0, 32'd1);
        send_command(FN_UPDATE, '0, '0, '0, QTY_MAX);
        send_command(FN_UPDATE, '1, '0, '0, 32'd1);
        send_command(FN_UPDATE, '0, '0, '0, QTY_MIN);
    endtask

    task automatic test_dump_records();
        send_command(FN_DUMP, $urandom, {$urandom, $urandom}, $urandom, $urandom);
    endtask

    task automatic test_random_fill();
        int n;
        n = 0;
        while (tbl_count < MAX_ENTRIES) begin
            if (n == 30)
                hold_sender_until_drained();
            send_random(55, 3);
            n++;
        end
    endtask

    task automatic test_random_full_table();
        int n;
        n = 0;
        send_command(FN_DUMP, '0, '0, '0, '0);
        send_command(FN_INSERT, pick_key(100), '1, '1, '1);
        while (items_sent < ITEM_TARGET || n < 40) begin
            send_random(30, 4);
            n++;
        end
    endtask

    initial begin : main_sequence
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_func     = FN_INSERT;
        s_key      = '0;
        s_rec_name = '0;
        s_quantity = '0;
        s_delta    = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_table();
        test_insert_extremes();
        test_duplicate_and_miss();
        test_update_saturation();
        test_dump_records();
        test_random_fill();
        test_random_full_table();

        hold_sender_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/krt_pkg.sv
hdl/krt_ctrl.sv
hdl/krt_datapath.sv
hdl/keyed_record_table_unit.sv
hdl/krt_checker.sv
tb/tb_keyed_record_table_unit.sv
